### design/sts_pkg.sv
// Package for the sorted table search block: sizes, status codes, FSM states.
`timescale 1ns / 1ps
package sts_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int NUM_TABLES  = 32;

  // Derived widths
  localparam int IDX_W   = $clog2(TABLE_DEPTH);           // slot index
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);       // fill count, holds DEPTH
  localparam int TAB_W   = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
  localparam int ADDR_W  = TAB_W + IDX_W;
  localparam int MEM_DEPTH = NUM_TABLES * (1 << IDX_W);

  // Fixed field widths of the stream words
  localparam int TID_W   = 5;
  localparam int COORD_W = 32;
  localparam int EIDX_W  = 10;
  localparam int STAT_W  = 2;

  // Word packing
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 3;

  // Request kinds
  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PROBE,
    S_CMP,
    S_RESP
  } sts_state_t;

endpackage

### design/sorted_table_binary_search.sv
// Sorted start-coordinate tables with append and midpoint binary search.
`timescale 1ns / 1ps
// Usage:
//   Input stream (in_*): one word per request. in_tuser is the mode
//   (0 append coordinate, 1 search for key); in_tdata carries the table id
//   and the coordinate. Output stream (out_*): exactly one word per request
//   with status, found flag and entry index.
//   Each table keeps its entries in one shared block memory; the search
//   loop uses one memory read port and 32-bit equal and greater-than compares per probe.
// Sequence:
//   Append or rejected request: S_DECODE, then S_RESP, then out_tvalid.
//   Search: S_DECODE, then P probes, P <= ceil(log2(count+1)), then S_RESP.
//   Each probe is a registered memory read in S_PROBE followed by a compare
//   in S_CMP.
// Flow:
//   One request in flight at a time; in_tready is high only while idle, so
//   a new word is taken only after the previous request leaves S_RESP.
//   A finished word sits in the output register, so the next request is
//   accepted while the previous word still waits for out_tready.
// Reset:
//   rst_n (synchronous, active low) empties every table by clearing the fill
//   counts; memory contents are not cleared. A stalled receiver only holds
//   the result in the output register; the block waits in its response
//   state until the output register frees up.
module sorted_table_binary_search (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [sts_pkg::IN_TDATA_W-1:0]    in_tdata,   // [4:0] table_id, [36:5] coordinate
  input  logic                              in_tuser,   // [0] mode
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [sts_pkg::OUT_TDATA_W-1:0]   out_tdata,  // [9:0] entry_index
  output logic [sts_pkg::OUT_TUSER_W-1:0]   out_tuser   // [1:0] status, [2] found
);
  import sts_pkg::*;

  // Control and request registers
  sts_state_t           state_r, state_nxt;
  logic                 mode_r, mode_nxt;
  logic                 tid_ok_r, tid_ok_nxt;
  logic [TAB_W-1:0]     tab_r, tab_nxt;
  logic [COORD_W-1:0]   coord_r, coord_nxt;

  // Search window: [lo, end) over the table entries
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     end_r, end_nxt;
  logic [IDX_W-1:0]     mid_r, mid_nxt;

  // Pending result
  logic [STAT_W-1:0]    res_status_r, res_status_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [EIDX_W-1:0]    res_idx_r, res_idx_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    out_status_r, out_status_nxt;
  logic                 out_found_r, out_found_nxt;
  logic [EIDX_W-1:0]    out_idx_r, out_idx_nxt;

  // Fill counts per table
  logic [CNT_W-1:0]     cnt_r [NUM_TABLES];
  logic [CNT_W-1:0]     cnt_q;
  logic                 cnt_we;
  logic [CNT_W-1:0]     cnt_wdata;

  // Entry memory
  logic [COORD_W-1:0]   mem [MEM_DEPTH];
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [COORD_W-1:0]   mem_rdata_r;

  // Datapath helpers
  logic [CNT_W:0]       mid_sum;
  logic [CNT_W-1:0]     mid_full;
  logic [CNT_W-1:0]     mid_inc;
  logic                 out_free;

  assign cnt_q    = cnt_r[tab_r];
  assign mid_sum  = {1'b0, lo_r} + {1'b0, end_r} - {{CNT_W{1'b0}}, 1'b1};
  assign mid_full = mid_sum[CNT_W:1];
  assign mid_inc  = {{(CNT_W-IDX_W){1'b0}}, mid_r} + {{(CNT_W-1){1'b0}}, 1'b1};
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-EIDX_W){1'b0}}, out_idx_r};
  assign out_tuser  = {out_found_r, out_status_r};

  // Sequencer: next state and datapath controls
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    tid_ok_nxt     = tid_ok_r;
    tab_nxt        = tab_r;
    coord_nxt      = coord_r;
    lo_nxt         = lo_r;
    end_nxt        = end_r;
    mid_nxt        = mid_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_found_nxt  = out_found_r;
    out_idx_nxt    = out_idx_r;
    cnt_we         = 1'b0;
    cnt_wdata      = cnt_q + {{(CNT_W-1){1'b0}}, 1'b1};
    mem_we         = 1'b0;
    mem_waddr      = {tab_r, cnt_q[IDX_W-1:0]};
    mem_raddr      = {tab_r, mid_full[IDX_W-1:0]};

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt   = in_tuser;
          tid_ok_nxt = (32'(in_tdata[TID_W-1:0]) < 32'(NUM_TABLES));
          tab_nxt    = TAB_W'(in_tdata[TID_W-1:0]);
          coord_nxt  = in_tdata[TID_W +: COORD_W];
          state_nxt  = S_DECODE;
        end
      end

      S_DECODE: begin
        res_found_nxt = 1'b0;
        res_idx_nxt   = '0;
        state_nxt     = S_RESP;
        if (!tid_ok_r) begin
          res_status_nxt = (mode_r == MODE_APPEND) ? ST_FULL : ST_UNKNOWN;
        end else if (mode_r == MODE_APPEND) begin
          if (cnt_q >= CNT_W'(TABLE_DEPTH)) begin
            res_status_nxt = ST_FULL;
          end else begin
            mem_we         = 1'b1;
            cnt_we         = 1'b1;
            res_status_nxt = ST_OK;
            res_idx_nxt    = EIDX_W'(cnt_q);
          end
        end else if (cnt_q == '0) begin
          res_status_nxt = ST_UNKNOWN;
        end else begin
          lo_nxt    = '0;
          end_nxt   = cnt_q;
          state_nxt = S_PROBE;
        end
      end

      // Issue the memory read at the window midpoint
      S_PROBE: begin
        mid_nxt   = mid_full[IDX_W-1:0];
        state_nxt = S_CMP;
      end

      // Compare the probed entry with the key and narrow the window
      S_CMP: begin
        res_status_nxt = ST_OK;
        res_found_nxt  = 1'b0;
        res_idx_nxt    = '0;
        if (mem_rdata_r == coord_r) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = EIDX_W'(mid_r);
          state_nxt     = S_RESP;
        end else if (mem_rdata_r > coord_r) begin
          end_nxt   = {{(CNT_W-IDX_W){1'b0}}, mid_r};
          state_nxt = (lo_r >= {{(CNT_W-IDX_W){1'b0}}, mid_r}) ? S_RESP : S_PROBE;
        end else begin
          lo_nxt    = mid_inc;
          state_nxt = (mid_inc >= end_r) ? S_RESP : S_PROBE;
        end
      end

      // Hand the result to the output register once it is free
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_found_nxt  = res_found_r;
          out_idx_nxt    = res_idx_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    tid_ok_r     <= tid_ok_nxt;
    tab_r        <= tab_nxt;
    coord_r      <= coord_nxt;
    lo_r         <= lo_nxt;
    end_r        <= end_nxt;
    mid_r        <= mid_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_idx_r    <= res_idx_nxt;
    out_status_r <= out_status_nxt;
    out_found_r  <= out_found_nxt;
    out_idx_r    <= out_idx_nxt;
  end

  // Fill counts, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TABLES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cnt_we) begin
      cnt_r[tab_r] <= cnt_wdata;
    end
  end

  // Entry memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= coord_r;
    end
  end

  // Entry memory read port, registered data
  always_ff @(posedge clk) begin
    mem_rdata_r <= mem[mem_raddr];
  end

  // Assertions
  a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (lo_r < end_r))
    else $error("search window empty at probe");

  a_window_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE || state_r == S_CMP) |-> (end_r <= cnt_q))
    else $error("search window beyond table fill");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECODE && tid_ok_r) |-> (cnt_q <= CNT_W'(TABLE_DEPTH)))
    else $error("table fill count exceeds depth");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_status_r == ST_OK))
    else $error("hit reported with error status");

  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_DECODE))
    else $error("accepted word not decoded next cycle");

endmodule
